// ===== rtl/fcp_pkg.sv =====
// Shared types and constants for the framed comma-separated coordinate parser.
`default_nettype none

package fcp_pkg;

  localparam int MAX_PAYLOAD_DEF = 49;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int FIELD_COUNT     = 5;

  localparam logic [7:0] HEAD_BYTE_RST = 8'd91;
  localparam logic [7:0] END_BYTE_RST  = 8'd93;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Register index is paddr[2] (word addresses 0 and 4).
  typedef enum logic {
    REG_HEAD_BYTE = 1'b0,
    REG_END_BYTE  = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_NONE   = 2'd0,
    PH_SPACE  = 2'd1,
    PH_DIGITS = 2'd2,
    PH_STOP   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] head_byte;
    logic [7:0] end_byte;
  } cfg_t;

  typedef struct packed {
    logic [15:0] red_x;
    logic [15:0] red_y;
    logic [15:0] green_x;
    logic [15:0] green_y;
    logic [7:0]  near_flag;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/fcp_in_if.sv =====
// Input byte channel: valid/ready handshake carrying one received byte.
`default_nettype none

interface fcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/fcp_out_if.sv =====
// Result channel: valid/ready handshake carrying the five parsed values.
`default_nettype none

interface fcp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_x;
  logic [15:0] red_y;
  logic [15:0] green_x;
  logic [15:0] green_y;
  logic [7:0]  near_flag;

  modport source (output valid, output red_x, output red_y, output green_x,
                  output green_y, output near_flag, input ready);
  modport sink   (input valid, input red_x, input red_y, input green_x,
                  input green_y, input near_flag, output ready);
endinterface

`default_nettype wire

// ===== rtl/fcp_parser.sv =====
// Packet framing and comma-separated integer parse state, one byte per cycle.
`default_nettype none

module fcp_parser #(
  parameter int MAX_PAYLOAD = fcp_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         byte_vld,
  input  wire logic [7:0]   rx_byte,
  input  fcp_pkg::cfg_t     cfg,
  output logic              emit,
  output fcp_pkg::res_t     res
);
  import fcp_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

  logic             in_packet_r, in_packet_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       field_r, field_nxt;
  phase_t           phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [15:0]      acc_r, acc_nxt;
  logic             ended_r, ended_nxt;
  res_t             stored_r, stored_nxt;

  logic        is_sp, is_sign, is_digit;
  logic [15:0] tok_val, acc_base, acc_mul;
  logic [2:0]  field_inc;
  res_t        fin_res;
  phase_t      ph;

  assign emit = in_packet_r && (rx_byte == cfg.end_byte);
  assign res  = fin_res;

  assign is_sp    = (rx_byte == CHAR_SPACE) || (rx_byte >= CHAR_TAB && rx_byte <= CHAR_CR);
  assign is_sign  = (rx_byte == CHAR_MINUS) || (rx_byte == CHAR_PLUS);
  assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);

  assign tok_val   = neg_r ? 16'(16'd0 - acc_r) : acc_r;
  assign field_inc = (field_r < 3'(FIELD_COUNT)) ? 3'(field_r + 3'd1) : field_r;

  // a fresh token starts from zero
  assign acc_base = (phase_r == PH_NONE) ? 16'd0 : acc_r;
  assign acc_mul  = 16'({acc_base, 3'b000} + {acc_base, 1'b0} + {12'd0, rx_byte[3:0]});
  assign ph       = (phase_r == PH_NONE) ? PH_SPACE : phase_r;

  // stored values with the token in progress written back
  always_comb begin
    fin_res = stored_r;
    if (phase_r != PH_NONE) begin
      case (field_r)
        3'd0:    fin_res.red_x     = tok_val;
        3'd1:    fin_res.red_y     = tok_val;
        3'd2:    fin_res.green_x   = tok_val;
        3'd3:    fin_res.green_y   = tok_val;
        3'd4:    fin_res.near_flag = tok_val[7:0];
        default: fin_res = stored_r;
      endcase
    end
  end

  always_comb begin
    in_packet_nxt = in_packet_r;
    cnt_nxt       = cnt_r;
    field_nxt     = field_r;
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    ended_nxt     = ended_r;
    stored_nxt    = stored_r;
    if (byte_vld) begin
      if (!in_packet_r || emit) begin
        if (emit) begin
          stored_nxt    = fin_res;
          in_packet_nxt = 1'b0;
        end else if (rx_byte == cfg.head_byte) begin
          in_packet_nxt = 1'b1;
        end
        cnt_nxt   = '0;
        field_nxt = 3'd0;
        phase_nxt = PH_NONE;
        neg_nxt   = 1'b0;
        acc_nxt   = 16'd0;
        ended_nxt = 1'b0;
      end else if (!ended_r) begin
        if (cnt_r >= CNT_W'(MAX_PAYLOAD)) begin
          ended_nxt = 1'b1;
        end else begin
          cnt_nxt = CNT_W'(cnt_r + 1'b1);
          if (rx_byte == CHAR_NUL) begin
            ended_nxt = 1'b1;
          end else if (rx_byte == CHAR_COMMA) begin
            if (phase_r != PH_NONE) begin
              stored_nxt = fin_res;
              field_nxt  = field_inc;
              phase_nxt  = PH_NONE;
              neg_nxt    = 1'b0;
              acc_nxt    = 16'd0;
            end
          end else begin
            neg_nxt   = (phase_r == PH_NONE) ? 1'b0 : neg_r;
            acc_nxt   = acc_base;
            phase_nxt = ph;
            if (ph == PH_SPACE && is_sp) begin
              phase_nxt = PH_SPACE;
            end else if (ph == PH_SPACE && is_sign) begin
              neg_nxt   = (rx_byte == CHAR_MINUS);
              phase_nxt = PH_DIGITS;
            end else if (ph == PH_SPACE || ph == PH_DIGITS) begin
              if (is_digit) begin
                acc_nxt   = acc_mul;
                phase_nxt = PH_DIGITS;
              end else begin
                phase_nxt = PH_STOP;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r <= 1'b0;
      cnt_r       <= '0;
      field_r     <= 3'd0;
      phase_r     <= PH_NONE;
      neg_r       <= 1'b0;
      acc_r       <= 16'd0;
      ended_r     <= 1'b0;
      stored_r    <= '0;
    end else begin
      in_packet_r <= in_packet_nxt;
      cnt_r       <= cnt_nxt;
      field_r     <= field_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      ended_r     <= ended_nxt;
      stored_r    <= stored_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/framed_csv_coordinate_parser_core.sv =====
// Top level: framed comma-separated coordinate parser with APB config port.
//
// Usage:
//   in_ch  - one received byte per transaction (valid/ready).
//   out_ch - one transaction per closing byte seen inside a packet, carrying
//            red_x, red_y, green_x, green_y and near_flag.
//   APB    - register 0 (addr 0x0) head_byte, register 1 (addr 0x4) end_byte;
//            pready is tied high, write at the access phase. Write only idle.
// Throughput: one byte per cycle while no closing byte is held. A taken byte sits
//   in the input register; its parse update is applied as it leaves that register,
//   and a closing byte leaving it also loads the result register, which drives
//   out_ch.valid.
// Stall: while a result waits, ordinary bytes keep flowing; only a second
//   closing byte holds in the input register until the result is taken, and
//   in_ch.ready then drops.
// Reset (rst_n low, synchronous): out of packet, parse state and stored values
//   cleared, head_byte = 0x5B, end_byte = 0x5D, no result pending.
`default_nettype none

module framed_csv_coordinate_parser_core #(
  parameter int MAX_PAYLOAD = fcp_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  fcp_in_if.sink                               in_ch,
  fcp_out_if.source                            out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fcp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [fcp_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [fcp_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready
);
  import fcp_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       s1_vld_r, s1_vld_nxt;
  logic [7:0] s1_byte_r, s1_byte_nxt;
  logic       out_vld_r, out_vld_nxt;
  res_t       out_res_r, out_res_nxt;

  logic     emit, slot_free, s1_adv, in_acc, cfg_wr;
  res_t     res;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    prdata  = '0;
    case (reg_idx)
      REG_HEAD_BYTE: begin
        prdata = CFG_DATA_W'(cfg_r.head_byte);
        if (cfg_wr) cfg_nxt.head_byte = pwdata[7:0];
      end
      REG_END_BYTE: begin
        prdata = CFG_DATA_W'(cfg_r.end_byte);
        if (cfg_wr) cfg_nxt.end_byte = pwdata[7:0];
      end
      default: prdata = '0;
    endcase
  end

  fcp_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (s1_adv),
    .rx_byte  (s1_byte_r),
    .cfg      (cfg_r),
    .emit     (emit),
    .res      (res)
  );

  // only a closing byte needs room in the result register
  assign slot_free   = !out_vld_r || out_ch.ready;
  assign s1_adv      = s1_vld_r && (!emit || slot_free);
  assign in_ch.ready = !s1_vld_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    s1_byte_nxt = s1_byte_r;
    if (in_acc) begin
      s1_vld_nxt  = 1'b1;
      s1_byte_nxt = in_ch.rx_byte;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (s1_adv && emit) begin
      out_vld_nxt = 1'b1;
      out_res_nxt = res;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head_byte <= HEAD_BYTE_RST;
      cfg_r.end_byte  <= END_BYTE_RST;
      s1_vld_r        <= 1'b0;
      out_vld_r       <= 1'b0;
    end else begin
      cfg_r     <= cfg_nxt;
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.red_x     = out_res_r.red_x;
  assign out_ch.red_y     = out_res_r.red_y;
  assign out_ch.green_x   = out_res_r.green_x;
  assign out_ch.green_y   = out_res_r.green_y;
  assign out_ch.near_flag = out_res_r.near_flag;

`ifndef SYNTH
  // a held byte must be a closing byte blocked by an untaken result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_adv) |-> (emit && out_vld_r && !out_ch.ready))
    else $error("input stage stalled without a pending result");

  // a new result only follows a closing byte that advanced
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_nxt && !(out_vld_r && !out_ch.ready)) |-> (s1_adv && emit))
    else $error("result loaded without a closing byte");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_vld_r && !s1_vld_r))
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_framed_csv_coordinate_parser_core.sv =====
// Testbench: framed CSV coordinate parser, driven byte by byte against a local parse predictor.
`timescale 1ns / 1ps

module tb_framed_csv_coordinate_parser_core;
  import fcp_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  fcp_in_if  in_bus ();
  fcp_out_if out_bus ();

  framed_csv_coordinate_parser_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parse predictor: framing config, frame/token state, held coordinates
  // ---------------------------------------------------------------------------
  logic [7:0] cfg_head = HEAD_BYTE_RST;
  logic [7:0] cfg_close = END_BYTE_RST;

  bit         fr_open = 1'b0;
  int         fr_count = 0;
  int         tok_idx = 0;
  phase_t     tok_phase = PH_NONE;
  bit         tok_neg = 1'b0;
  logic [15:0] tok_acc = '0;
  bit         text_done = 1'b0;
  res_t       coords = '0;

  res_t       coords_due[$];
  int         errors = 0;
  int         fed_items = 0;
  bit         idle_en = 1'b1;
  int         sink_hold = 0;
  res_t       want;

  logic [7:0] frame_bytes[$];
  logic [7:0] blanks[6] = '{CHAR_SPACE, CHAR_TAB, 8'h0A, 8'h0B, 8'h0C, CHAR_CR};

  task automatic clear_frame();
    fr_count  = 0;
    tok_idx   = 0;
    tok_phase = PH_NONE;
    tok_neg   = 1'b0;
    tok_acc   = '0;
    text_done = 1'b0;
  endtask

  task automatic commit_token();
    logic [15:0] v;
    if (tok_phase == PH_NONE) return;
    v = tok_neg ? (16'd0 - tok_acc) : tok_acc;
    case (tok_idx)
      0: coords.red_x = v;
      1: coords.red_y = v;
      2: coords.green_x = v;
      3: coords.green_y = v;
      4: coords.near_flag = v[7:0];
      default: ;
    endcase
    if (tok_idx < FIELD_COUNT) tok_idx++;
    tok_phase = PH_NONE;
    tok_neg   = 1'b0;
    tok_acc   = '0;
  endtask

  // Returns 0 for bytes dropped while outside a frame.
  task automatic parse_byte(input logic [7:0] c, output bit counted);
    counted = 1'b1;
    if (!fr_open) begin
      if (c == cfg_head) begin
        fr_open = 1'b1;
        clear_frame();
      end else begin
        counted = 1'b0;
      end
      return;
    end
    // closing byte wins over everything else inside a frame
    if (c == cfg_close) begin
      commit_token();
      fr_open = 1'b0;
      clear_frame();
      coords_due.push_back(coords);
      return;
    end
    if (text_done) return;
    if (fr_count >= MAX_PAYLOAD_DEF) begin
      text_done = 1'b1;
      return;
    end
    fr_count++;
    if (c == CHAR_NUL) begin
      text_done = 1'b1;
      return;
    end
    if (c == CHAR_COMMA) begin
      commit_token();
      return;
    end
    if (tok_phase == PH_NONE) begin
      tok_phase = PH_SPACE;
      tok_neg   = 1'b0;
      tok_acc   = '0;
    end
    if (tok_phase == PH_SPACE) begin
      if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) return;
      if (c == CHAR_MINUS || c == CHAR_PLUS) begin
        tok_neg   = (c == CHAR_MINUS);
        tok_phase = PH_DIGITS;
        return;
      end
      tok_phase = PH_DIGITS;
    end
    if (tok_phase == PH_DIGITS) begin
      if (c >= CHAR_ZERO && c <= CHAR_NINE)
        tok_acc = tok_acc * 16'd10 + {8'h00, c - CHAR_ZERO};
      else
        tok_phase = PH_STOP;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte sender, register writes, drain
  // ---------------------------------------------------------------------------
  // Leaves valid high after the transaction; callers that stop sending lower it.
  task automatic send_byte(input logic [7:0] c);
    bit counted;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.rx_byte <= c;
    do @(posedge clk); while (!in_bus.ready);
    parse_byte(c, counted);
    if (counted) fed_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_frame(input string payload);
    send_byte(cfg_head);
    send_text(payload);
    send_byte(cfg_close);
  endtask

  task automatic send_queued();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  // Stop sending, let every pending result come out, then let the pipe settle.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (coords_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_HEAD_BYTE) cfg_head = val;
    else cfg_close = val;
    // leave the bus idle between writes
    @(posedge clk);
  endtask

  task automatic set_framing(input logic [7:0] opener, input logic [7:0] closer);
    wait_drained();
    write_reg(REG_HEAD_BYTE, opener);
    write_reg(REG_END_BYTE, closer);
  endtask

  // ---------------------------------------------------------------------------
  // Random frame builder
  // ---------------------------------------------------------------------------
  task automatic add_token();
    int sel;
    int n_dig;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) frame_bytes.push_back(blanks[$urandom_range(0, 5)]);
    sel = $urandom_range(0, 5);
    if (sel == 0) frame_bytes.push_back(CHAR_MINUS);
    else if (sel == 1) frame_bytes.push_back(CHAR_PLUS);
    n_dig = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
    repeat (n_dig) frame_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 9) == 0) begin
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 2)) frame_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic build_frame();
    int kind;
    int n_tok;
    int span;
    frame_bytes.delete();
    kind = $urandom_range(0, 11);
    if (kind == 0) begin
      // line noise, any byte value, no framing
      repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    frame_bytes.push_back(cfg_head);
    if (kind == 1) begin
      repeat ($urandom_range(0, 20)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 2) begin
      // long payload, near or past the parse limit
      span = $urandom_range(MAX_PAYLOAD_DEF - 3, MAX_PAYLOAD_DEF + 12);
      while (frame_bytes.size() <= span) begin
        add_token();
        frame_bytes.push_back(CHAR_COMMA);
      end
    end else if (kind == 3) begin
      ;  // empty frame, back-to-back closers stress the output stall
    end else begin
      n_tok = $urandom_range(0, 7);
      if ($urandom_range(0, 7) == 0) frame_bytes.push_back(CHAR_COMMA);
      for (int i = 0; i < n_tok; i++) begin
        if (i > 0) frame_bytes.push_back(CHAR_COMMA);
        if ($urandom_range(0, 5) == 0) frame_bytes.push_back(CHAR_COMMA);
        if ($urandom_range(0, 19) == 0) frame_bytes.push_back(CHAR_NUL);
        add_token();
      end
      if ($urandom_range(0, 7) == 0) frame_bytes.push_back(CHAR_COMMA);
    end
    frame_bytes.push_back(cfg_close);
  endtask

  task automatic run_traffic(input int n_items);
    int start;
    int frames;
    start  = fed_items;
    frames = 0;
    while (fed_items - start < n_items) begin
      build_frame();
      send_queued();
      frames++;
      if (frames % 40 == 0) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_values();
    // closers and junk while idle are dropped; empty frame shows reset contents
    send_text("]x5]");
    send_frame("");
  endtask

  task automatic test_token_rules();
    send_frame("12,34,56,78,9");
    send_frame("");
    send_frame("-1,+65535,65536, \011\012\013\014\015 7,-0");
    send_frame("5");
    send_frame(",,,300,,");
    send_frame("-12a9,abc,-,+,99999");
    send_frame("1,2,3,4,5,6,7");
    send_frame("1[2,3");
  endtask

  task automatic test_frame_limits();
    // zero byte ends text, token in progress still counts
    send_byte(cfg_head);
    send_text("4,5");
    send_byte(CHAR_NUL);
    send_text(",6");
    send_byte(cfg_close);
    // payload longer than the parse window
    frame_bytes.delete();
    frame_bytes.push_back(cfg_head);
    frame_bytes.push_back(CHAR_ZERO + 8'd7);
    frame_bytes.push_back(CHAR_COMMA);
    repeat (MAX_PAYLOAD_DEF - 3) frame_bytes.push_back(CHAR_SPACE);
    frame_bytes.push_back(CHAR_ZERO + 8'd8);
    frame_bytes.push_back(CHAR_ZERO + 8'd9);
    frame_bytes.push_back(cfg_close);
    send_queued();
  endtask

  task automatic test_config_framing();
    set_framing(8'h00, 8'hFF);
    send_byte(CHAR_NUL);
    send_text("12,3");
    send_byte(8'hFF);
    set_framing(8'hFF, 8'h00);
    send_byte(8'hFF);
    send_text("-7,8");
    send_byte(CHAR_NUL);
    // opener equal to closer, and equal to the separator
    set_framing(CHAR_COMMA, CHAR_COMMA);
    send_text(",5,,6,");
  endtask

  task automatic test_random_traffic();
    set_framing(HEAD_BYTE_RST, END_BYTE_RST);
    run_traffic(280);
    set_framing(8'h00, 8'hFF);
    run_traffic(180);
    set_framing(8'h7E, 8'h7E);
    run_traffic(180);
    set_framing(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_traffic(180);
  endtask

  task automatic test_steady_stream();
    set_framing(HEAD_BYTE_RST, END_BYTE_RST);
    idle_en = 1'b0;
    run_traffic(280);
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stall bursts on ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold     <= sink_hold - 1;
      out_bus.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      sink_hold     <= $urandom_range(0, 5);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (coords_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d %0d",
                 $time, out_bus.red_x, out_bus.red_y, out_bus.green_x, out_bus.green_y,
                 out_bus.near_flag);
        errors++;
      end else begin
        want = coords_due.pop_front();
        check_field("red_x", want.red_x, out_bus.red_x);
        check_field("red_y", want.red_y, out_bus.red_y);
        check_field("green_x", want.green_x, out_bus.green_x);
        check_field("green_y", want.green_y, out_bus.green_y);
        check_field("near_flag", want.near_flag, out_bus.near_flag);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[framed_csv_coordinate_parser_core] ERROR");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.rx_byte <= 8'h00;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_token_rules();
    test_frame_limits();
    test_config_framing();
    test_random_traffic();
    test_steady_stream();

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[framed_csv_coordinate_parser_core] OK");
    end else begin
      $display("[framed_csv_coordinate_parser_core] ERROR");
    end
    $finish;
  end

endmodule
